// ===== rtl/core/cwc_pkg.sv =====
// Shared types and constants for the color window centroid block.
// Used by the pixel accumulator, the shared iterative unit and the top level.
// No dependencies.
package cwc_pkg;

    // Widths of the fields and of the running frame totals.
    localparam int PIX_W   = 8;
    localparam int LIMIT_W = 9;
    localparam int SPREAD_W = 16;
    localparam int CNT_N_W = 17;
    localparam int SUM_W   = 24;
    localparam int SQ_W    = 32;
    localparam int Q88_W   = 16;

    // Shared unit: accumulator width, multiplier/dividend register width.
    localparam int UNIT_W    = 52;
    localparam int MP_W      = 34;
    localparam int DIV_W     = 32;
    localparam int STEP_W    = 6;
    localparam int MUL_STEPS = 34;
    localparam int DIV_STEPS = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLOR_LOW  = 2'd0;
    localparam logic [1:0] CFG_COLOR_HIGH = 2'd1;
    localparam logic [1:0] CFG_ROW_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_SPREAD_LIM = 2'd3;

    localparam logic [SPREAD_W-1:0] SPREAD_LIM_RESET = 16'd100;

    typedef struct packed {
        logic [PIX_W-1:0]    color_low;
        logic [PIX_W-1:0]    color_high;
        logic [LIMIT_W-1:0]  row_limit;
        logic [SPREAD_W-1:0] spread_limit;
    } t_cfg;

    typedef struct packed {
        logic [CNT_N_W-1:0] n;
        logic [SUM_W-1:0]   row;
        logic [SUM_W-1:0]   col;
        logic [SQ_W-1:0]    sq;
        logic [PIX_W-1:0]   least;
    } t_totals;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic              start;
        t_unit_op          op;
        logic [UNIT_W-1:0] init;
        logic [UNIT_W-1:0] a;
        logic [MP_W-1:0]   b;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LATCH,
        ST_MUL_NS,
        ST_MUL_CC,
        ST_MUL_NN,
        ST_MUL_LN,
        ST_DIV_ROW,
        ST_DIV_COL,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/cwc_accum.sv =====
// Per-pixel match test and running frame totals (count, sums, sum of squares,
// least column). Depends on cwc_pkg.
module cwc_accum
    import cwc_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_value,
    input  logic [PIX_W-1:0] i_row,
    input  logic [PIX_W-1:0] i_col,
    input  logic             i_last,
    output t_totals          o_frame
);

    localparam logic [CNT_N_W-1:0] PIX_MAX  = CNT_N_W'(MAX_ROWS * MAX_COLS);
    localparam logic [LIMIT_W-1:0] ROWS_LIM = LIMIT_W'(MAX_ROWS);
    localparam logic [LIMIT_W-1:0] COLS_LIM = LIMIT_W'(MAX_COLS);

    t_totals              r_tot;
    t_totals              clear_tot;
    logic                 match;
    logic                 take;
    logic [2*PIX_W-1:0]   col_sq;

    assign clear_tot = '{n: '0, row: '0, col: '0, sq: '0, least: '1};

    // Match test against the window, the row limit and the raster size.
    assign match = ({1'b0, i_row} < i_cfg.row_limit) && ({1'b0, i_row} < ROWS_LIM) &&
                   ({1'b0, i_col} < COLS_LIM) &&
                   (i_cfg.color_low <= i_value) && (i_value <= i_cfg.color_high);
    assign take   = match && (r_tot.n < PIX_MAX);
    assign col_sq = i_col * i_col;

    // Totals including the current pixel; the top level latches them at frame end.
    always_comb begin
        o_frame = r_tot;
        if (take) begin
            o_frame.n   = r_tot.n + CNT_N_W'(1);
            o_frame.row = r_tot.row + SUM_W'(i_row);
            o_frame.col = r_tot.col + SUM_W'(i_col);
            o_frame.sq  = r_tot.sq + SQ_W'(col_sq);
            if (i_col < r_tot.least) begin
                o_frame.least = i_col;
            end
        end
    end

    // Running totals clear after the last pixel of each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= clear_tot;
        end else if (i_accept) begin
            r_tot <= i_last ? clear_tot : o_frame;
        end
    end

endmodule

// ===== rtl/core/cwc_iter_unit.sv =====
// Shared iterative arithmetic unit: shift-add multiply and restoring divide,
// one step per cycle through a single adder/subtractor. Depends on cwc_pkg.
module cwc_iter_unit
    import cwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_req         i_req,
    output t_unit_stat        o_stat,
    output logic [UNIT_W-1:0] o_result
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_unit_op          r_op;
    logic [UNIT_W-1:0] r_acc;
    logic [UNIT_W-1:0] r_mc;
    logic [MP_W-1:0]   r_mp;

    logic [UNIT_W-1:0] n_acc;
    logic [UNIT_W-1:0] n_mc;
    logic [MP_W-1:0]   n_mp;
    logic [UNIT_W-1:0] shift_rem;
    logic [UNIT_W-1:0] add_x;
    logic [UNIT_W-1:0] add_y;
    logic              is_div;
    logic [UNIT_W:0]   sum;

    // One shared adder; for division it subtracts and its carry means no borrow.
    assign is_div    = (r_op == UOP_DIV);
    assign shift_rem = {r_acc[UNIT_W-2:0], r_mp[DIV_W-1]};
    assign add_x     = is_div ? shift_rem : r_acc;
    assign add_y     = is_div ? ~r_mc : r_mc;
    assign sum       = {1'b0, add_x} + {1'b0, add_y} + (UNIT_W+1)'(is_div);

    // Step update for either operation.
    always_comb begin
        if (is_div) begin
            n_acc = sum[UNIT_W] ? sum[UNIT_W-1:0] : shift_rem;
            n_mc  = r_mc;
            n_mp  = {r_mp[MP_W-2:0], sum[UNIT_W]};
        end else begin
            n_acc = r_mp[0] ? sum[UNIT_W-1:0] : r_acc;
            n_mc  = {r_mc[UNIT_W-2:0], 1'b0};
            n_mp  = {1'b0, r_mp[MP_W-1:1]};
        end
    end

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= UOP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == UOP_DIV) ? STEP_W'(DIV_STEPS - 1)
                                                : STEP_W'(MUL_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.init;
            r_mc  <= i_req.a;
            r_mp  <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mc  <= n_mc;
            r_mp  <= n_mp;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = is_div ? UNIT_W'(r_mp[DIV_W-1:0]) : r_acc;

endmodule

// ===== rtl/core/color_window_centroid.sv =====
// Top level of the color window centroid block: configuration registers,
// frame-end sequencer and result register. Depends on cwc_pkg, cwc_accum and
// cwc_iter_unit.
//
// Usage: pixels enter on the s_axis channel, one request per pixel, with
// tlast on the last pixel of a frame. Ordinary pixels are taken at one per
// clock while the sequencer is idle; the match test and accumulation
// finish in the cycle of acceptance. On the last pixel the block drops
// s_axis_tready and runs its sequencer: four shift-add multiplies of 34
// steps and up to two restoring divides of 32 steps, all on one shared
// adder. The column divide is skipped when the spread test picks the least
// column, and all arithmetic is skipped when nothing matched. One result
// comes per frame. The result sits in an output register; the block takes
// the next frame's pixels while it waits. If a second frame finishes while
// the first result is still held, the sequencer waits until m_axis_tready
// takes it. Reset (synchronous, active low) clears the totals, loads the
// register defaults and empties the output. Configuration is written
// through i_cfg_we/i_cfg_addr/i_cfg_data by the user, only while no frame
// end is in progress; the block does not enforce this.
module color_window_centroid
    import cwc_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [SPREAD_W-1:0] i_cfg_data,
    // Pixel stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,  // pixel_value[7:0], pix_row[15:8], pixel_col[23:16]
    input  logic                s_axis_tlast,  // frame_end
    // Result stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,  // mean_row[15:0], result_col[31:16]
    output logic [1:0]          m_axis_tuser   // found[0], spread[1]
);

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    t_totals           frame_tot;
    t_totals           r_f;
    t_unit_req         unit_req;
    t_unit_stat        unit_stat;
    logic [UNIT_W-1:0] unit_res;
    logic              s_accept;
    logic              op_state;

    logic [UNIT_W-1:0] r_lhs;
    logic [UNIT_W-1:0] r_cc;
    logic              r_spread;
    logic [Q88_W-1:0]  r_mean_row;
    logic [Q88_W-1:0]  r_res_col;

    logic              r_m_valid;
    logic [Q88_W-1:0]  r_m_row;
    logic [Q88_W-1:0]  r_m_col;
    logic              r_m_found;
    logic              r_m_spread;
    logic              out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_low    <= '0;
            r_cfg.color_high   <= '1;
            r_cfg.row_limit    <= LIMIT_W'(MAX_ROWS);
            r_cfg.spread_limit <= SPREAD_LIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COLOR_LOW:  r_cfg.color_low    <= i_cfg_data[PIX_W-1:0];
                CFG_COLOR_HIGH: r_cfg.color_high   <= i_cfg_data[PIX_W-1:0];
                CFG_ROW_LIMIT:  r_cfg.row_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_SPREAD_LIM: r_cfg.spread_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cwc_accum #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (s_accept),
        .i_value  (s_axis_tdata[7:0]),
        .i_row    (s_axis_tdata[15:8]),
        .i_col    (s_axis_tdata[23:16]),
        .i_last   (s_axis_tlast),
        .o_frame  (frame_tot)
    );

    cwc_iter_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (unit_req),
        .o_stat   (unit_stat),
        .o_result (unit_res)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (s_accept && s_axis_tlast) n_state = ST_LATCH;
            ST_LATCH:   n_state = (r_f.n == '0) ? ST_EMIT : ST_MUL_NS;
            ST_MUL_NS:  if (unit_stat.done) n_state = ST_MUL_CC;
            ST_MUL_CC:  if (unit_stat.done) n_state = ST_MUL_NN;
            ST_MUL_NN:  if (unit_stat.done) n_state = ST_MUL_LN;
            ST_MUL_LN:  if (unit_stat.done) n_state = ST_DIV_ROW;
            ST_DIV_ROW: if (unit_stat.done) n_state = r_spread ? ST_EMIT : ST_DIV_COL;
            ST_DIV_COL: if (unit_stat.done) n_state = ST_EMIT;
            ST_EMIT:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Unit requests: an operation starts as its state is entered.
    always_comb begin
        op_state      = 1'b1;
        unit_req.op   = UOP_MUL;
        unit_req.init = '0;
        unit_req.a    = '0;
        unit_req.b    = '0;
        unique case (n_state)
            ST_MUL_NS: begin
                unit_req.a = UNIT_W'(r_f.sq);
                unit_req.b = MP_W'(r_f.n);
            end
            ST_MUL_CC: begin
                unit_req.a = UNIT_W'(r_f.col);
                unit_req.b = MP_W'(r_f.col);
            end
            ST_MUL_NN: begin
                unit_req.a = UNIT_W'(r_f.n);
                unit_req.b = MP_W'(r_f.n);
            end
            ST_MUL_LN: begin
                // n squared is still on the unit's result as this operation starts.
                unit_req.init = r_cc;
                unit_req.a    = UNIT_W'(unit_res[MP_W-1:0]);
                unit_req.b    = MP_W'(r_cfg.spread_limit);
            end
            ST_DIV_ROW: begin
                unit_req.op = UOP_DIV;
                unit_req.a  = UNIT_W'(r_f.n);
                unit_req.b  = MP_W'({r_f.row, 8'b0});
            end
            ST_DIV_COL: begin
                unit_req.op = UOP_DIV;
                unit_req.a  = UNIT_W'(r_f.n);
                unit_req.b  = MP_W'({r_f.col, 8'b0});
            end
            default: op_state = 1'b0;
        endcase
        unit_req.start = op_state && (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Frame snapshot and intermediate results.
    always_ff @(posedge i_clk) begin
        if (s_accept && s_axis_tlast) begin
            r_f <= frame_tot;
        end
        if (r_state == ST_LATCH) begin
            r_spread   <= 1'b0;
            r_mean_row <= '0;
            r_res_col  <= '0;
        end
        if (unit_stat.done) begin
            unique case (r_state)
                ST_MUL_NS: r_lhs <= unit_res;
                ST_MUL_CC: r_cc  <= unit_res;
                ST_MUL_LN: begin
                    r_spread  <= (r_lhs > unit_res);
                    r_res_col <= {r_f.least, 8'b0};
                end
                ST_DIV_ROW: r_mean_row <= unit_res[Q88_W-1:0];
                ST_DIV_COL: r_res_col  <= unit_res[Q88_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_m_row    <= r_mean_row;
            r_m_col    <= r_res_col;
            r_m_found  <= (r_f.n != '0);
            r_m_spread <= r_spread;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_col, r_m_row};
    assign m_axis_tuser  = {r_m_spread, r_m_found};

`ifndef NO_ASSERTIONS
    // The shared unit is never restarted in the middle of an operation.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_req.start |-> !unit_stat.busy)
        else $error("shared unit started while busy");

    // No pixel is taken while the shared unit is working on a frame end.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_stat.busy |-> !s_axis_tready)
        else $error("pixel accepted during frame-end computation");

    // An empty frame reports zeros and no spread.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (!m_axis_tuser[1] && m_axis_tdata == '0))
        else $error("empty frame with nonzero result");

    // A spread result carries the least column, which has no fraction bits.
    a_spread_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[23:16] == 8'd0))
        else $error("spread result with fractional column");
`endif

endmodule
